// ===== hw/rtl/line_pair_intersection_assert.svh =====
// Assertion macros for the line pair intersection block
`ifndef LINE_PAIR_INTERSECTION_ASSERT_SVH
`define LINE_PAIR_INTERSECTION_ASSERT_SVH

// Property checked at every clock edge outside reset
`define LPI_ASSERT_COMB(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("line_pair_intersection: check failed");

// Implication checked in the same cycle outside reset
`define LPI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("line_pair_intersection: implication failed");

`endif

// ===== hw/rtl/lpi_pkg.sv =====
package lpi_pkg;

    // Fixed port field widths
    localparam int FIELD_W   = 32;
    localparam int IN_FIELDS = 6;
    localparam int REL_W     = 2;

    // Relation codes
    localparam logic [REL_W-1:0] REL_INTERSECT = 2'd0;
    localparam logic [REL_W-1:0] REL_PARALLEL  = 2'd1;
    localparam logic [REL_W-1:0] REL_SAME      = 2'd2;

    // Control flags carried beside the divider data
    typedef struct packed {
        logic valid;
        logic det_zero;
        logic same;
        logic neg_x;
        logic neg_y;
        logic big_x;
        logic big_y;
    } flags_t;

endpackage

// ===== hw/rtl/line_pair_intersection.sv =====
// line_pair_intersection: intersection of two lines a*x + b*y + c = 0 by Cramer's rule.
// Input channel s_*: one transaction carries both lines, six signed coefficients
// with FRAC_BITS fractional bits; only the low COEF_WIDTH bits of each are used.
// Result channel m_*: m_tuser holds relation (0 intersecting, 1 parallel, 2 same)
// and the overflow flag; m_tdata holds x and y, zero unless intersecting.
// Coordinates are truncated toward zero and saturate to the COEF_WIDTH range.
// Registers from input transaction to result valid, in order: input register,
// multiply, difference, magnitude, pre-check, the quotient bit stages of the
// restoring divider, saturation. A new pair is taken every cycle while the
// receiver does not stall; the rate is one item per cycle, set by the fully
// pipelined divider chain. The whole pipeline advances while the output register
// is empty or being taken, so s_tready follows !m_tvalid || m_tready; a stalled
// receiver holds the result and freezes every stage, nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; payload is kept.
module line_pair_intersection #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // a1, b1, c1, a2, b2, c2 (32 bits each, from bit 0 up)
    input  logic [191:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // x_coord [31:0], y_coord [63:32]
    output logic [63:0]   m_tdata,
    // relation [1:0], overflow [2]
    output logic [2:0]    m_tuser
);

    `include "line_pair_intersection_assert.svh"

    localparam int C  = COEF_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * C;
    localparam int NW = 2 * C + F;
    localparam int RW = ((C + F > 2 * C) ? C + F : 2 * C) + 1;
    localparam logic [C-1:0] PMAX = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] NMAX = {1'b1, {(C-1){1'b0}}};

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 0: input register
    logic                v0_reg;
    logic signed [C-1:0] a1_reg, b1_reg, c1_reg, a2_reg, b2_reg, c2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
        if (adv) begin
            a1_reg <= s_tdata[0*lpi_pkg::FIELD_W +: C];
            b1_reg <= s_tdata[1*lpi_pkg::FIELD_W +: C];
            c1_reg <= s_tdata[2*lpi_pkg::FIELD_W +: C];
            a2_reg <= s_tdata[3*lpi_pkg::FIELD_W +: C];
            b2_reg <= s_tdata[4*lpi_pkg::FIELD_W +: C];
            c2_reg <= s_tdata[5*lpi_pkg::FIELD_W +: C];
        end
    end

    // Stage 1: six products
    logic                 v1_reg;
    logic signed [PW-1:0] p_a1b2_reg, p_a2b1_reg, p_c2b1_reg;
    logic signed [PW-1:0] p_c1b2_reg, p_a2c1_reg, p_a1c2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
        if (adv) begin
            p_a1b2_reg <= PW'(a1_reg) * PW'(b2_reg);
            p_a2b1_reg <= PW'(a2_reg) * PW'(b1_reg);
            p_c2b1_reg <= PW'(c2_reg) * PW'(b1_reg);
            p_c1b2_reg <= PW'(c1_reg) * PW'(b2_reg);
            p_a2c1_reg <= PW'(a2_reg) * PW'(c1_reg);
            p_a1c2_reg <= PW'(a1_reg) * PW'(c2_reg);
        end
    end

    // Stage 2: determinant and numerators, same-line test
    logic                 v2_reg, same2_reg;
    logic signed [PW:0]   det_reg, numx_reg, numy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            det_reg   <= (PW+1)'(p_a1b2_reg) - (PW+1)'(p_a2b1_reg);
            numx_reg  <= (PW+1)'(p_c2b1_reg) - (PW+1)'(p_c1b2_reg);
            numy_reg  <= (PW+1)'(p_a2c1_reg) - (PW+1)'(p_a1c2_reg);
            same2_reg <= (p_a2c1_reg == p_a1c2_reg) && (p_c1b2_reg == p_c2b1_reg);
        end
    end

    // Stage 3: magnitudes and quotient signs
    lpi_pkg::flags_t   f3_reg;
    logic [PW-1:0]     dmag_reg, nxmag_reg, nymag_reg;
    logic [PW:0]       det_neg, numx_neg, numy_neg;

    assign det_neg  = -det_reg;
    assign numx_neg = -numx_reg;
    assign numy_neg = -numy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f3_reg.valid <= 1'b0;
        end else if (adv) begin
            f3_reg.valid <= v2_reg;
        end
        if (adv) begin
            f3_reg.det_zero <= (det_reg == '0);
            f3_reg.same     <= same2_reg;
            f3_reg.neg_x    <= numx_reg[PW] ^ det_reg[PW];
            f3_reg.neg_y    <= numy_reg[PW] ^ det_reg[PW];
            f3_reg.big_x    <= 1'b0;
            f3_reg.big_y    <= 1'b0;
            dmag_reg  <= det_reg[PW]  ? det_neg[PW-1:0]  : det_reg[PW-1:0];
            nxmag_reg <= numx_reg[PW] ? numx_neg[PW-1:0] : numx_reg[PW-1:0];
            nymag_reg <= numy_reg[PW] ? numy_neg[PW-1:0] : numy_reg[PW-1:0];
        end
    end

    // Divider pipeline: index 0 is the pre-check, 1..C one quotient bit each
    lpi_pkg::flags_t f_reg  [0:C];
    logic [PW-1:0]   d_reg  [0:C];
    logic [NW-1:0]   nx_reg [0:C];
    logic [NW-1:0]   ny_reg [0:C];
    logic [RW-1:0]   rx_reg [0:C];
    logic [RW-1:0]   ry_reg [0:C];
    logic [C-1:0]    qx_reg [0:C];
    logic [C-1:0]    qy_reg [0:C];

    logic [NW-1:0] nx_sh, ny_sh;
    logic [RW-1:0] rx_init, ry_init, d_ext;

    assign nx_sh   = NW'(nxmag_reg) << F;
    assign ny_sh   = NW'(nymag_reg) << F;
    assign rx_init = RW'(nx_sh >> C);
    assign ry_init = RW'(ny_sh >> C);
    assign d_ext   = RW'(dmag_reg);

    // Pre-check: quotient of 2^C or more saturates whatever its sign
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg[0].valid <= 1'b0;
        end else if (adv) begin
            f_reg[0].valid <= f3_reg.valid;
        end
        if (adv) begin
            f_reg[0].det_zero <= f3_reg.det_zero;
            f_reg[0].same     <= f3_reg.same;
            f_reg[0].neg_x    <= f3_reg.neg_x;
            f_reg[0].neg_y    <= f3_reg.neg_y;
            f_reg[0].big_x    <= (rx_init >= d_ext);
            f_reg[0].big_y    <= (ry_init >= d_ext);
            d_reg[0]  <= dmag_reg;
            nx_reg[0] <= nx_sh;
            ny_reg[0] <= ny_sh;
            rx_reg[0] <= rx_init;
            ry_reg[0] <= ry_init;
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
        end
    end

    // Restoring division steps, one per stage
    for (genvar k = 1; k <= C; k++) begin : g_div
        logic [RW-1:0] tx, ty, dk;
        logic          gex, gey;

        assign dk  = RW'(d_reg[k-1]);
        assign tx  = {rx_reg[k-1][RW-2:0], nx_reg[k-1][C-k]};
        assign ty  = {ry_reg[k-1][RW-2:0], ny_reg[k-1][C-k]};
        assign gex = (tx >= dk);
        assign gey = (ty >= dk);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                f_reg[k].valid <= 1'b0;
            end else if (adv) begin
                f_reg[k].valid <= f_reg[k-1].valid;
            end
            if (adv) begin
                f_reg[k].det_zero <= f_reg[k-1].det_zero;
                f_reg[k].same     <= f_reg[k-1].same;
                f_reg[k].neg_x    <= f_reg[k-1].neg_x;
                f_reg[k].neg_y    <= f_reg[k-1].neg_y;
                f_reg[k].big_x    <= f_reg[k-1].big_x;
                f_reg[k].big_y    <= f_reg[k-1].big_y;
                d_reg[k]  <= d_reg[k-1];
                nx_reg[k] <= nx_reg[k-1];
                ny_reg[k] <= ny_reg[k-1];
                rx_reg[k] <= gex ? tx - dk : tx;
                ry_reg[k] <= gey ? ty - dk : ty;
                qx_reg[k] <= {qx_reg[k-1][C-2:0], gex};
                qy_reg[k] <= {qy_reg[k-1][C-2:0], gey};
            end
        end
    end

    // Output stage: sign, saturation and relation
    lpi_pkg::flags_t     ff;
    logic [C-1:0]        qx, qy;
    logic                sat_x, sat_y;
    logic signed [C-1:0] x_val, y_val;

    assign ff = f_reg[C];
    assign qx = qx_reg[C];
    assign qy = qy_reg[C];

    always_comb begin
        sat_x = ff.big_x || (ff.neg_x ? (qx > NMAX) : (qx > PMAX));
        sat_y = ff.big_y || (ff.neg_y ? (qy > NMAX) : (qy > PMAX));
        if (ff.neg_x) begin
            x_val = sat_x ? NMAX : -qx;
        end else begin
            x_val = sat_x ? PMAX : qx;
        end
        if (ff.neg_y) begin
            y_val = sat_y ? NMAX : -qy;
        end else begin
            y_val = sat_y ? PMAX : qy;
        end
    end

    logic                      out_valid_reg;
    logic [lpi_pkg::REL_W-1:0] rel_reg;
    logic                      ovf_reg;
    logic [31:0]               x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= ff.valid;
        end
        if (adv) begin
            if (ff.det_zero) begin
                rel_reg <= ff.same ? lpi_pkg::REL_SAME : lpi_pkg::REL_PARALLEL;
                ovf_reg <= 1'b0;
                x_reg   <= '0;
                y_reg   <= '0;
            end else begin
                rel_reg <= lpi_pkg::REL_INTERSECT;
                ovf_reg <= sat_x || sat_y;
                x_reg   <= 32'(x_val);
                y_reg   <= 32'(y_val);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {y_reg, x_reg};
    assign m_tuser  = {ovf_reg, rel_reg};

    // Checks
    logic rel_known, no_cross;
    assign rel_known = (rel_reg == lpi_pkg::REL_INTERSECT) || (rel_reg == lpi_pkg::REL_PARALLEL)
                    || (rel_reg == lpi_pkg::REL_SAME);
    assign no_cross  = m_tvalid && (rel_reg != lpi_pkg::REL_INTERSECT);

    `LPI_ASSERT_COMB(a_ready_follows_output, s_tready == (!m_tvalid || m_tready))
    `LPI_ASSERT_COMB(a_rel_code, !m_tvalid || rel_known)
    `LPI_ASSERT_IMPL(a_no_point_unless_cross, no_cross, m_tdata == '0 && !ovf_reg)
    `LPI_ASSERT_IMPL(a_div_valid_on_stall, $past(!adv && aresetn), $stable(f_reg[C].valid))

endmodule
